>>> rtl/scle_pkg.sv
// ----------------------------------------------------------------------------
// scle_pkg
// Shared types, codes and the scan code set 1 key table for the line editor.
// ----------------------------------------------------------------------------
package scle_pkg;

	// Scan code bytes of interest
	localparam logic [7:0] SC_PREFIX   = 8'hE0;
	localparam logic [7:0] SC_LAST_KEY = 8'h3A;
	localparam logic [6:0] SC_LCTRL    = 7'h1D;
	localparam logic [6:0] SC_LSHIFT   = 7'h2A;
	localparam logic [6:0] SC_RSHIFT   = 7'h36;
	localparam logic [6:0] SC_ALT      = 7'h38;
	localparam logic [6:0] SC_CAPS     = 7'h3A;
	localparam logic [5:0] SC_SYM_END  = 6'h0E;

	// ASCII characters the editor produces itself
	localparam logic [6:0] CH_NUL = 7'h00;
	localparam logic [6:0] CH_BS  = 7'h08;
	localparam logic [6:0] CH_NL  = 7'h0A;
	localparam logic [6:0] CH_SP  = 7'h20;

	// Result kinds
	localparam logic [1:0] KIND_ECHO    = 2'd0;
	localparam logic [1:0] KIND_LINE    = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CHAR,
		ST_UNK,
		ST_BS1,
		ST_BS2,
		ST_BS3,
		ST_ECHO_NL,
		ST_LINE_OUT,
		ST_LINE_WAIT,
		ST_LINE_NL
	} scle_state_t;

	// Outcome of decoding one byte
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_UNKNOWN,
		ACT_CHAR,
		ACT_BS,
		ACT_ENTER
	} scle_act_t;

	// Source of the next result loaded into the output register
	typedef enum logic [2:0] {
		SRC_CHAR,
		SRC_UNK,
		SRC_BS,
		SRC_SPACE,
		SRC_NL_ECHO,
		SRC_LINE,
		SRC_NL_LINE
	} scle_src_t;

	typedef struct packed {
		logic      load;      // capture the accepted byte
		logic      exec;      // decode the byte and update editor state
		logic      emit;      // load a result into the output register
		scle_src_t src;
		logic      last;
		logic      ptr_clr;   // rewind the line read pointer
		logic      ptr_inc;   // step to the next stored character
		logic      line_clr;  // empty the line
	} scle_cmd_t;

	typedef struct packed {
		scle_act_t act;
		logic      out_free;   // output register can take a result this cycle
		logic      line_empty;
		logic      line_end;   // read pointer is on the newest stored character
	} scle_sts_t;

	// Keys that take their shifted column only with shift (caps lock ignored)
	function automatic logic is_symbol_key(input logic [5:0] idx);
		is_symbol_key = (idx < SC_SYM_END) || (idx == 6'h29) || (idx == 6'h1A) ||
			(idx == 6'h1B) || (idx == 6'h2B) || (idx == 6'h27) || (idx == 6'h28) ||
			(idx == 6'h33) || (idx == 6'h34) || (idx == 6'h35);
	endfunction

	// Scan code set 1 to ASCII; sel picks the shifted column
	function automatic logic [6:0] key_char(input logic [5:0] idx, input logic sel);
		case (idx)
			6'h01: key_char = 7'h1B;
			6'h02: key_char = sel ? 7'h21 : 7'h31;
			6'h03: key_char = sel ? 7'h40 : 7'h32;
			6'h04: key_char = sel ? 7'h23 : 7'h33;
			6'h05: key_char = sel ? 7'h24 : 7'h34;
			6'h06: key_char = sel ? 7'h25 : 7'h35;
			6'h07: key_char = sel ? 7'h5E : 7'h36;
			6'h08: key_char = sel ? 7'h26 : 7'h37;
			6'h09: key_char = sel ? 7'h2A : 7'h38;
			6'h0A: key_char = sel ? 7'h28 : 7'h39;
			6'h0B: key_char = sel ? 7'h29 : 7'h30;
			6'h0C: key_char = sel ? 7'h5F : 7'h2D;
			6'h0D: key_char = sel ? 7'h2B : 7'h3D;
			6'h0E: key_char = CH_BS;
			6'h0F: key_char = 7'h09;
			6'h10: key_char = sel ? 7'h51 : 7'h71;
			6'h11: key_char = sel ? 7'h57 : 7'h77;
			6'h12: key_char = sel ? 7'h45 : 7'h65;
			6'h13: key_char = sel ? 7'h52 : 7'h72;
			6'h14: key_char = sel ? 7'h54 : 7'h74;
			6'h15: key_char = sel ? 7'h59 : 7'h79;
			6'h16: key_char = sel ? 7'h55 : 7'h75;
			6'h17: key_char = sel ? 7'h49 : 7'h69;
			6'h18: key_char = sel ? 7'h4F : 7'h6F;
			6'h19: key_char = sel ? 7'h50 : 7'h70;
			6'h1A: key_char = sel ? 7'h7B : 7'h5B;
			6'h1B: key_char = sel ? 7'h7D : 7'h5D;
			6'h1C: key_char = CH_NL;
			6'h1E: key_char = sel ? 7'h41 : 7'h61;
			6'h1F: key_char = sel ? 7'h53 : 7'h73;
			6'h20: key_char = sel ? 7'h44 : 7'h64;
			6'h21: key_char = sel ? 7'h46 : 7'h66;
			6'h22: key_char = sel ? 7'h47 : 7'h67;
			6'h23: key_char = sel ? 7'h48 : 7'h68;
			6'h24: key_char = sel ? 7'h4A : 7'h6A;
			6'h25: key_char = sel ? 7'h4B : 7'h6B;
			6'h26: key_char = sel ? 7'h4C : 7'h6C;
			6'h27: key_char = sel ? 7'h3A : 7'h3B;
			6'h28: key_char = sel ? 7'h22 : 7'h27;
			6'h29: key_char = sel ? 7'h7E : 7'h60;
			6'h2B: key_char = sel ? 7'h7C : 7'h5C;
			6'h2C: key_char = sel ? 7'h5A : 7'h7A;
			6'h2D: key_char = sel ? 7'h58 : 7'h78;
			6'h2E: key_char = sel ? 7'h43 : 7'h63;
			6'h2F: key_char = sel ? 7'h56 : 7'h76;
			6'h30: key_char = sel ? 7'h42 : 7'h62;
			6'h31: key_char = sel ? 7'h4E : 7'h6E;
			6'h32: key_char = sel ? 7'h4D : 7'h6D;
			6'h33: key_char = sel ? 7'h3C : 7'h2C;
			6'h34: key_char = sel ? 7'h3E : 7'h2E;
			6'h35: key_char = sel ? 7'h3F : 7'h2F;
			6'h37: key_char = 7'h2A;
			6'h39: key_char = CH_SP;
			default: key_char = CH_NUL;
		endcase
	endfunction

endpackage

>>> rtl/scle_ctrl.sv
// ----------------------------------------------------------------------------
// scle_ctrl
// Sequencer for the line editor: accepts a byte, has it decoded, then
// walks the results of that byte out through the output register.
// ----------------------------------------------------------------------------
module scle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  scle_pkg::scle_sts_t sts,
	output scle_pkg::scle_cmd_t cmd
);

	scle_pkg::scle_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scle_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			scle_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = scle_pkg::ST_DECODE;
			end
			scle_pkg::ST_DECODE: begin
				unique case (sts.act)
					scle_pkg::ACT_UNKNOWN: state_nxt = scle_pkg::ST_UNK;
					scle_pkg::ACT_CHAR:    state_nxt = scle_pkg::ST_CHAR;
					scle_pkg::ACT_BS:      state_nxt = scle_pkg::ST_BS1;
					scle_pkg::ACT_ENTER:   state_nxt = scle_pkg::ST_ECHO_NL;
					default:               state_nxt = scle_pkg::ST_IDLE;
				endcase
			end
			scle_pkg::ST_CHAR, scle_pkg::ST_UNK, scle_pkg::ST_BS3: begin
				if (sts.out_free) state_nxt = scle_pkg::ST_IDLE;
			end
			scle_pkg::ST_BS1: begin
				if (sts.out_free) state_nxt = scle_pkg::ST_BS2;
			end
			scle_pkg::ST_BS2: begin
				if (sts.out_free) state_nxt = scle_pkg::ST_BS3;
			end
			scle_pkg::ST_ECHO_NL: begin
				if (sts.out_free) begin
					state_nxt = sts.line_empty ? scle_pkg::ST_LINE_NL : scle_pkg::ST_LINE_OUT;
				end
			end
			scle_pkg::ST_LINE_OUT: begin
				if (sts.out_free) begin
					state_nxt = sts.line_end ? scle_pkg::ST_LINE_NL : scle_pkg::ST_LINE_WAIT;
				end
			end
			scle_pkg::ST_LINE_WAIT: begin
				state_nxt = scle_pkg::ST_LINE_OUT;
			end
			scle_pkg::ST_LINE_NL: begin
				if (sts.out_free) state_nxt = scle_pkg::ST_IDLE;
			end
			default: state_nxt = scle_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.src      = scle_pkg::SRC_CHAR;
		unique case (state_q)
			scle_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			scle_pkg::ST_DECODE: begin
				cmd.exec    = 1'b1;
				cmd.ptr_clr = 1'b1;
			end
			scle_pkg::ST_CHAR: begin
				cmd.emit = sts.out_free;
				cmd.src  = scle_pkg::SRC_CHAR;
				cmd.last = 1'b1;
			end
			scle_pkg::ST_UNK: begin
				cmd.emit = sts.out_free;
				cmd.src  = scle_pkg::SRC_UNK;
				cmd.last = 1'b1;
			end
			scle_pkg::ST_BS1: begin
				cmd.emit = sts.out_free;
				cmd.src  = scle_pkg::SRC_BS;
			end
			scle_pkg::ST_BS2: begin
				cmd.emit = sts.out_free;
				cmd.src  = scle_pkg::SRC_SPACE;
			end
			scle_pkg::ST_BS3: begin
				cmd.emit = sts.out_free;
				cmd.src  = scle_pkg::SRC_BS;
				cmd.last = 1'b1;
			end
			scle_pkg::ST_ECHO_NL: begin
				cmd.emit = sts.out_free;
				cmd.src  = scle_pkg::SRC_NL_ECHO;
			end
			scle_pkg::ST_LINE_OUT: begin
				cmd.emit    = sts.out_free;
				cmd.src     = scle_pkg::SRC_LINE;
				cmd.ptr_inc = sts.out_free;
			end
			scle_pkg::ST_LINE_WAIT: begin
				cmd.src = scle_pkg::SRC_LINE;
			end
			scle_pkg::ST_LINE_NL: begin
				cmd.emit     = sts.out_free;
				cmd.src      = scle_pkg::SRC_NL_LINE;
				cmd.last     = 1'b1;
				cmd.line_clr = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/scle_datapath.sv
// ----------------------------------------------------------------------------
// scle_datapath
// Byte decode, modifier flags, edit line memory with its count and read
// pointer, and the output register.
// ----------------------------------------------------------------------------
module scle_datapath #(
	parameter int LINE_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          scan_byte,
	input  scle_pkg::scle_cmd_t cmd,
	output scle_pkg::scle_sts_t sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          kind,
	output logic [6:0]          char_code,
	output logic                last,
	output logic                ctrl_held,
	output logic                alt_held
);

	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam logic [AW-1:0] FULL_COUNT = AW'(LINE_DEPTH - 1);

	logic [7:0]    byte_q;
	logic          prefix_q, shift_q, ctrl_q, alt_q, caps_q;
	logic [AW-1:0] count_q, ptr_q;
	logic [6:0]    ch_q, rd_data_q;
	logic [6:0]    line_mem [LINE_DEPTH];

	logic          out_valid_q, last_q, ctrl_out_q, alt_out_q;
	logic [1:0]    kind_q;
	logic [6:0]    char_q;

	// Decode signals
	logic          is_prefix, is_break, make_ok, sel, mod_key, wr_en;
	logic [6:0]    low7, ch;
	scle_pkg::scle_act_t act;

	assign is_prefix = (byte_q == scle_pkg::SC_PREFIX);
	assign is_break  = byte_q[7];
	assign low7      = byte_q[6:0];
	assign make_ok   = prefix_q ? (low7 == scle_pkg::SC_ALT || low7 == scle_pkg::SC_LCTRL)
		: (byte_q != 8'h00 && byte_q <= scle_pkg::SC_LAST_KEY);
	assign sel       = (!prefix_q && scle_pkg::is_symbol_key(byte_q[5:0])) ? shift_q
		: (shift_q ^ caps_q);
	assign ch        = scle_pkg::key_char(byte_q[5:0], sel);
	assign mod_key   = (ch == scle_pkg::CH_NUL);

	// Classify the byte
	always_comb begin
		act = scle_pkg::ACT_NONE;
		if (!is_prefix && !is_break) begin
			if (!make_ok) begin
				act = scle_pkg::ACT_UNKNOWN;
			end else if (mod_key) begin
				act = scle_pkg::ACT_NONE;
			end else if (ch == scle_pkg::CH_NL) begin
				act = scle_pkg::ACT_ENTER;
			end else if (ch == scle_pkg::CH_BS) begin
				act = (count_q == '0) ? scle_pkg::ACT_NONE : scle_pkg::ACT_BS;
			end else if (count_q < FULL_COUNT) begin
				act = scle_pkg::ACT_CHAR;
			end
		end
	end

	assign wr_en = cmd.exec && (act == scle_pkg::ACT_CHAR);

	// Capture the accepted byte and the decoded character
	always_ff @(posedge clk) begin
		if (cmd.load) byte_q <= scan_byte;
		if (cmd.exec) ch_q <= ch;
	end

	// Update prefix and modifier flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			alt_q    <= 1'b0;
			caps_q   <= 1'b0;
		end else if (cmd.exec) begin
			prefix_q <= is_prefix;
			if (!is_prefix) begin
				if (is_break) begin
					if (low7 == scle_pkg::SC_LCTRL) begin
						ctrl_q <= 1'b0;
					end else if (!prefix_q && (low7 == scle_pkg::SC_LSHIFT ||
							low7 == scle_pkg::SC_RSHIFT)) begin
						shift_q <= 1'b0;
					end else if (low7 == scle_pkg::SC_ALT) begin
						alt_q <= 1'b0;
					end
				end else if (make_ok && mod_key) begin
					if (low7 == scle_pkg::SC_LCTRL) begin
						ctrl_q <= 1'b1;
					end else if (low7 == scle_pkg::SC_LSHIFT || low7 == scle_pkg::SC_RSHIFT) begin
						shift_q <= 1'b1;
					end else if (low7 == scle_pkg::SC_ALT) begin
						alt_q <= 1'b1;
					end else if (low7 == scle_pkg::SC_CAPS) begin
						caps_q <= ~caps_q;
					end
				end
			end
		end
	end

	// Advance line count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.line_clr) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.exec && act == scle_pkg::ACT_BS) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Line memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) line_mem[count_q] <= ch;
		rd_data_q <= line_mem[ptr_q];
	end

	// Output register; hold while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q     <= cmd.last;
			ctrl_out_q <= ctrl_q;
			alt_out_q  <= alt_q;
			unique case (cmd.src)
				scle_pkg::SRC_CHAR: begin
					kind_q <= scle_pkg::KIND_ECHO;
					char_q <= ch_q;
				end
				scle_pkg::SRC_UNK: begin
					kind_q <= scle_pkg::KIND_UNKNOWN;
					char_q <= scle_pkg::CH_NUL;
				end
				scle_pkg::SRC_BS: begin
					kind_q <= scle_pkg::KIND_ECHO;
					char_q <= scle_pkg::CH_BS;
				end
				scle_pkg::SRC_SPACE: begin
					kind_q <= scle_pkg::KIND_ECHO;
					char_q <= scle_pkg::CH_SP;
				end
				scle_pkg::SRC_NL_ECHO: begin
					kind_q <= scle_pkg::KIND_ECHO;
					char_q <= scle_pkg::CH_NL;
				end
				scle_pkg::SRC_LINE: begin
					kind_q <= scle_pkg::KIND_LINE;
					char_q <= rd_data_q;
				end
				scle_pkg::SRC_NL_LINE: begin
					kind_q <= scle_pkg::KIND_LINE;
					char_q <= scle_pkg::CH_NL;
				end
				default: begin
					kind_q <= scle_pkg::KIND_UNKNOWN;
					char_q <= scle_pkg::CH_NUL;
				end
			endcase
		end
	end

	// Status back to the sequencer
	always_comb begin
		sts            = '0;
		sts.act        = act;
		sts.out_free   = !out_valid_q || out_ready;
		sts.line_empty = (count_q == '0);
		sts.line_end   = ({1'b0, ptr_q} + 1'b1) == {1'b0, count_q};
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign char_code = char_q;
	assign last      = last_q;
	assign ctrl_held = ctrl_out_q;
	assign alt_held  = alt_out_q;

endmodule

>>> rtl/scancode_to_ascii_line_editor_core.sv
// Flow: an accepted byte is registered, decoded in the decode state, and its first
// result is then loaded into the output register. One byte is in work at a time; a
// byte may give no result, a character its echo, a backspace backspace, space,
// backspace, and enter a newline echo, then one line memory read per stored character.
// Reset: arst_n clears the modifier flags, prefix, line count and output valid;
// the line memory keeps no reset and is read only below the line count.
// ----------------------------------------------------------------------------
// scancode_to_ascii_line_editor_core
// Scan code set 1 keyboard decoder with echo and a line editor.
// ----------------------------------------------------------------------------
module scancode_to_ascii_line_editor_core #(
	parameter int LINE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [6:0] char_code,
	output logic       last,
	output logic       ctrl_held,
	output logic       alt_held
);

	scle_pkg::scle_cmd_t cmd;
	scle_pkg::scle_sts_t sts;

	// Sequencer
	scle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Decode, line storage and output register
	scle_datapath #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_byte (scan_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.char_code (char_code),
		.last      (last),
		.ctrl_held (ctrl_held),
		.alt_held  (alt_held)
	);

endmodule

>>> rtl/scle_checker.sv
// ----------------------------------------------------------------------------
// scle_checker
// Port-level checks for the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module scle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [6:0] char_code,
	input logic       last,
	input logic       ctrl_held,
	input logic       alt_held
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({kind, char_code, last, ctrl_held, alt_held}))
		else $error("result changed while stalled");

	// One byte in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("byte taken while previous byte in work");

	// Unknown key is a lone null result
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == scle_pkg::KIND_UNKNOWN |-> char_code == scle_pkg::CH_NUL && last)
		else $error("unknown key result malformed");

	// Completed line ends in newline
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == scle_pkg::KIND_LINE && last |-> char_code == scle_pkg::CH_NL)
		else $error("completed line does not end in newline");

	// Newline echo is never marked last; the delivered line follows it
	a_nl_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == scle_pkg::KIND_ECHO && char_code == scle_pkg::CH_NL |-> !last)
		else $error("newline echo marked last");

endmodule

bind scancode_to_ascii_line_editor_core scle_checker u_scle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.char_code (char_code),
	.last      (last),
	.ctrl_held (ctrl_held),
	.alt_held  (alt_held)
);

>>> tb/tb_scancode_to_ascii_line_editor_core.sv
// ----------------------------------------------------------------------------
// tb_scancode_to_ascii_line_editor_core
// Self-checking bench for the scan code set 1 decoder and line editor: a
// behavioral key decoder predicts every echo, line and unknown-key result,
// and a checker compares each output transfer against the oldest prediction
// under random idling and long output stalls.
// ----------------------------------------------------------------------------
module tb_scancode_to_ascii_line_editor_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH  = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 40;

	// Scan codes the bench drives by name
	localparam logic [6:0] SC_BKSP  = 7'h0E;
	localparam logic [6:0] SC_ENTER = 7'h1C;
	localparam logic [6:0] SC_ESC   = 7'h01;
	localparam logic [6:0] SC_TAB   = 7'h0F;
	localparam logic [6:0] SC_SPACE = 7'h39;
	localparam logic [6:0] SC_STAR  = 7'h37;
	localparam logic [6:0] SC_KEY_A = 7'h1E;
	localparam logic [6:0] SC_KEY_1 = 7'h02;
	localparam logic [6:0] SC_KEY_Q = 7'h10;
	localparam logic [7:0] SC_MAX   = 8'hFF;
	localparam logic [7:0] SC_ZERO  = 8'h00;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] char_code;
		logic       last;
		logic       ctrl;
		logic       alt;
	} key_result_t;

	// Unshifted and shifted ASCII per make code 0x00..0x3A
	logic [6:0] key_lower [0:58] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
	};
	logic [6:0] key_upper [0:58] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
	};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] scan_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [6:0] char_code;
	logic       last;
	logic       ctrl_held;
	logic       alt_held;

	// Predicted keyboard and editor state
	logic       prefix_armed;
	logic       shift_on;
	logic       ctrl_on;
	logic       alt_on;
	logic       caps_active;
	logic [6:0] line_buf [LINE_DEPTH];
	int         line_len;

	key_result_t pending_chars [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles   = 0;
	int cycle_count   = 0;
	int error_count   = 0;
	int bytes_sent    = 0;
	int results_seen  = 0;
	int lines_seen    = 0;

	scancode_to_ascii_line_editor_core #(
		.LINE_DEPTH(LINE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.scan_byte(scan_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.char_code(char_code),
		.last     (last),
		.ctrl_held(ctrl_held),
		.alt_held (alt_held)
	);

	always #2 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Drive output ready: long hold-off first, else random idling
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		key_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_chars.size() == 0) begin
				$error("unexpected result kind=%0d char_code=%h", kind, char_code);
				error_count++;
			end else begin
				exp_r = pending_chars.pop_front();
				if (kind !== exp_r.kind) begin
					$error("kind: expected %0d, actual %0d", exp_r.kind, kind);
					error_count++;
				end
				if (char_code !== exp_r.char_code) begin
					$error("char_code: expected %h, actual %h", exp_r.char_code, char_code);
					error_count++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0b, actual %0b", exp_r.last, last);
					error_count++;
				end
				if (ctrl_held !== exp_r.ctrl) begin
					$error("ctrl_held: expected %0b, actual %0b", exp_r.ctrl, ctrl_held);
					error_count++;
				end
				if (alt_held !== exp_r.alt) begin
					$error("alt_held: expected %0b, actual %0b", exp_r.alt, alt_held);
					error_count++;
				end
				if (exp_r.kind == scle_pkg::KIND_LINE && exp_r.last)
					lines_seen++;
			end
		end
	end

	// Keys whose shifted column ignores caps lock
	function automatic logic shift_only_key(input logic [5:0] idx);
		return idx inside {[6'h00:6'h0D], 6'h1A, 6'h1B, 6'h27, 6'h28, 6'h29, 6'h2B,
			[6'h33:6'h35]};
	endfunction

	function automatic void queue_char(input logic [1:0] k, input logic [6:0] ch,
		input logic is_last);
		pending_chars.push_back('{k, ch, is_last, ctrl_on, alt_on});
	endfunction

	// Decode one accepted byte and queue the results it causes
	task automatic decode_scan_byte(input logic [7:0] b);
		logic       prefixed;
		logic       sel;
		logic [5:0] idx;
		logic [6:0] ch;
		int         i;
		if (b == scle_pkg::SC_PREFIX) begin
			prefix_armed = 1'b1;
			return;
		end
		prefixed     = prefix_armed;
		prefix_armed = 1'b0;
		// release modifiers on break; everything else ignores breaks
		if (b[7]) begin
			if (b[6:0] == scle_pkg::SC_LCTRL)
				ctrl_on = 1'b0;
			else if (!prefixed && (b[6:0] == scle_pkg::SC_LSHIFT ||
					b[6:0] == scle_pkg::SC_RSHIFT))
				shift_on = 1'b0;
			else if (b[6:0] == scle_pkg::SC_ALT)
				alt_on = 1'b0;
			return;
		end
		if (prefixed ? !(b[6:0] == scle_pkg::SC_ALT || b[6:0] == scle_pkg::SC_LCTRL)
			: (b == SC_ZERO || b > scle_pkg::SC_LAST_KEY)) begin
			queue_char(scle_pkg::KIND_UNKNOWN, scle_pkg::CH_NUL, 1'b1);
			return;
		end
		idx = b[5:0];
		sel = (!prefixed && shift_only_key(idx)) ? shift_on : (shift_on ^ caps_active);
		ch  = sel ? key_upper[idx] : key_lower[idx];
		if (ch == scle_pkg::CH_NUL) begin
			if (b[6:0] == scle_pkg::SC_LCTRL)
				ctrl_on = 1'b1;
			else if (b[6:0] == scle_pkg::SC_LSHIFT || b[6:0] == scle_pkg::SC_RSHIFT)
				shift_on = 1'b1;
			else if (b[6:0] == scle_pkg::SC_ALT)
				alt_on = 1'b1;
			else if (b[6:0] == scle_pkg::SC_CAPS)
				caps_active = ~caps_active;
		end else if (ch == scle_pkg::CH_NL) begin
			queue_char(scle_pkg::KIND_ECHO, scle_pkg::CH_NL, 1'b0);
			for (i = 0; i < line_len; i++)
				queue_char(scle_pkg::KIND_LINE, line_buf[i], 1'b0);
			queue_char(scle_pkg::KIND_LINE, scle_pkg::CH_NL, 1'b1);
			line_len = 0;
		end else if (ch == scle_pkg::CH_BS) begin
			if (line_len > 0) begin
				queue_char(scle_pkg::KIND_ECHO, scle_pkg::CH_BS, 1'b0);
				queue_char(scle_pkg::KIND_ECHO, scle_pkg::CH_SP, 1'b0);
				queue_char(scle_pkg::KIND_ECHO, scle_pkg::CH_BS, 1'b1);
				line_len--;
			end
		end else if (line_len < LINE_DEPTH - 1) begin
			line_buf[line_len] = ch;
			line_len++;
			queue_char(scle_pkg::KIND_ECHO, ch, 1'b1);
		end
	endtask

	// Offer one byte, hold it until the transfer, then predict
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		scan_byte <= b;
		do @(posedge clk); while (!in_ready);
		decode_scan_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_chars.size() != 0)
			@(negedge clk);
	endtask

	// Pick a make code that stores a character in the line
	function automatic logic [7:0] pick_char_key();
		logic [7:0] c;
		c = 8'($urandom_range(1, 57));
		while (key_lower[c] == scle_pkg::CH_NUL || key_lower[c] == scle_pkg::CH_BS ||
			key_lower[c] == scle_pkg::CH_NL)
			c = 8'($urandom_range(1, 57));
		return c;
	endfunction

	// Walk the extremes, modifiers, prefixes and edit keys
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_byte(SC_ZERO);
		send_byte(SC_MAX);
		send_byte({1'b0, SC_BKSP});
		send_byte(scle_pkg::SC_PREFIX);
		send_byte(scle_pkg::SC_PREFIX);
		send_byte({1'b0, SC_ENTER});
		send_byte(scle_pkg::SC_LAST_KEY + 8'd1);
		send_byte(8'h7F);
		send_byte({1'b0, SC_KEY_A});
		send_byte({1'b0, scle_pkg::SC_LSHIFT});
		send_byte({1'b0, SC_KEY_1});
		send_byte({1'b0, SC_KEY_A});
		send_byte(scle_pkg::SC_PREFIX);
		send_byte({1'b1, scle_pkg::SC_LSHIFT});
		send_byte({1'b1, scle_pkg::SC_LSHIFT});
		send_byte({1'b0, scle_pkg::SC_CAPS});
		send_byte({1'b1, scle_pkg::SC_CAPS});
		send_byte({1'b0, SC_KEY_A});
		send_byte({1'b0, SC_KEY_1});
		send_byte({1'b0, scle_pkg::SC_RSHIFT});
		send_byte({1'b0, SC_KEY_A});
		send_byte({1'b1, scle_pkg::SC_RSHIFT});
		send_byte({1'b0, scle_pkg::SC_CAPS});
		send_byte({1'b0, scle_pkg::SC_LCTRL});
		send_byte(scle_pkg::SC_PREFIX);
		send_byte({1'b0, scle_pkg::SC_ALT});
		send_byte({1'b0, SC_KEY_Q});
		send_byte(scle_pkg::SC_PREFIX);
		send_byte({1'b1, scle_pkg::SC_ALT});
		send_byte({1'b1, scle_pkg::SC_LCTRL});
		send_byte(scle_pkg::SC_PREFIX);
		send_byte({1'b0, scle_pkg::SC_LSHIFT});
		send_byte({1'b0, SC_BKSP});
		send_byte({1'b0, SC_ESC});
		send_byte({1'b0, SC_TAB});
		send_byte({1'b0, SC_SPACE});
		send_byte({1'b0, SC_STAR});
		send_byte({1'b0, SC_ENTER});
		send_byte({1'b0, SC_ENTER});
		wait_results_drained();
	endtask

	// Fill the line, overflow it, edit at the edge, then flush the longest line
	task automatic test_line_full();
		int i;
		send_idle_pct = 10;
		recv_idle_pct = 10;
		for (i = 0; i < LINE_DEPTH; i++)
			send_byte(pick_char_key());
		send_byte({1'b0, SC_BKSP});
		send_byte(pick_char_key());
		send_byte(pick_char_key());
		send_byte({1'b0, SC_ENTER});
		wait_results_drained();
	endtask

	// Stall the output for a long stretch while bytes keep coming
	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles   = 600;
		for (i = 0; i < 10; i++)
			send_byte(pick_char_key());
		send_byte({1'b0, SC_ENTER});
		for (i = 0; i < 3; i++)
			send_byte(pick_char_key());
		send_byte({1'b0, SC_BKSP});
		// pause the sender until all results are out, then resume
		wait_results_drained();
		for (i = 0; i < 5; i++)
			send_byte(pick_char_key());
		send_byte({1'b0, SC_ENTER});
		wait_results_drained();
	endtask

	// Random typing sessions with modifiers, edits, flushes and noise
	task automatic test_random_typing(input int n_actions, input int snd_pct,
		input int rcv_pct);
		int         i;
		int         pick;
		logic [7:0] k;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (i = 0; i < n_actions; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				k = pick_char_key();
				send_byte(k);
				if ($urandom_range(0, 1))
					send_byte(k | 8'h80);
			end else if (pick < 63) begin
				send_byte({shift_on,
					$urandom_range(0, 1) ? scle_pkg::SC_LSHIFT : scle_pkg::SC_RSHIFT});
			end else if (pick < 67) begin
				send_byte({1'b0, scle_pkg::SC_CAPS});
				send_byte({1'b1, scle_pkg::SC_CAPS});
			end else if (pick < 72) begin
				if ($urandom_range(0, 1))
					send_byte(scle_pkg::SC_PREFIX);
				send_byte({ctrl_on, scle_pkg::SC_LCTRL});
			end else if (pick < 77) begin
				if ($urandom_range(0, 1))
					send_byte(scle_pkg::SC_PREFIX);
				send_byte({alt_on, scle_pkg::SC_ALT});
			end else if (pick < 83) begin
				send_byte({1'b0, SC_BKSP});
			end else if (pick < 90) begin
				send_byte({1'b0, SC_ENTER});
			end else begin
				if ($urandom_range(0, 1))
					send_byte(scle_pkg::SC_PREFIX);
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		wait_results_drained();
	endtask

	initial begin
		prefix_armed = 1'b0;
		shift_on     = 1'b0;
		ctrl_on      = 1'b0;
		alt_on       = 1'b0;
		caps_active  = 1'b0;
		line_len     = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_line_full();
		test_backpressure();
		test_random_typing(35, 21, 58);
		test_random_typing(35, 58, 21);
		test_random_typing(35, 0, 0);

		// let the block finish any trailing work before the verdict
		repeat (SETTLE) @(negedge clk);
		if (pending_chars.size() != 0) begin
			$error("%0d predicted results never arrived", pending_chars.size());
			error_count++;
		end
		$display("Sent %0d scan bytes; checked %0d results, %0d completed lines.",
			bytes_sent, results_seen, lines_seen);
		$display("Covered prefixes, breaks, modifiers, caps lock, full line and stalls.");
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/scle_pkg.sv
rtl/scle_ctrl.sv
rtl/scle_datapath.sv
rtl/scancode_to_ascii_line_editor_core.sv
rtl/scle_checker.sv
tb/tb_scancode_to_ascii_line_editor_core.sv
